>>> rtl/mfsd_pkg.sv
// mfsd_pkg: shared constants and payload types for the marker framed sample deframer
// used by the channel interfaces and the top level; no dependencies
package mfsd_pkg;

  localparam int COUNT_BITS     = 32;
  localparam int NUM_WORDS      = 3;
  localparam int WORD_BITS      = 32;
  localparam int WORD_IDX_BITS  = $clog2(NUM_WORDS + 1);
  localparam int MARKER_BITS    = 8;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic [MARKER_BITS-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                  frame_ready;
    logic                  frame_taken;
    logic [WORD_BITS-1:0]  time_word;
    logic [WORD_BITS-1:0]  eye_x_word;
    logic [WORD_BITS-1:0]  eye_y_word;
    logic [COUNT_BITS-1:0] frames_total;
    logic [COUNT_BITS-1:0] sync_error_total;
    logic [COUNT_BITS-1:0] overrun_total;
  } out_item_t;

endpackage

>>> rtl/mfsd_in_if.sv
// mfsd_in_if: valid/ready channel carrying bytes and read requests
// depends on mfsd_pkg
interface mfsd_in_if;
  logic               valid;
  logic               ready;
  mfsd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mfsd_out_if.sv
// mfsd_out_if: valid/ready channel carrying one status result per transaction
// depends on mfsd_pkg
interface mfsd_out_if;
  logic                valid;
  logic                ready;
  mfsd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/marker_framed_sample_deframer.sv
// marker_framed_sample_deframer: byte stream deframer with start and end markers
// depends on mfsd_pkg, mfsd_in_if and mfsd_out_if
//
// usage
//   req carries one transaction per item: cmd 0 delivers a received byte,
//   cmd 1 asks to take the latched frame. rsp returns exactly one status
//   result per request transaction: ready and taken flags, the three latched
//   words and the frame, sync error and overrun counters.
//   a frame is two start markers, twelve data bytes (three words, low byte
//   first) and two end markers; the marker values are set through the
//   cfg_we / cfg_index / cfg_data write port, by the user only while the
//   block is idle; the block does not enforce it. the result appears on
//   rsp in the cycle after the request is taken. throughput: one request
//   per cycle while rsp is not stalled; frame state and output move together.
//   stall: req.ready follows rsp, a request is taken when the output
//   register is empty or its result is taken in the same cycle; while the
//   receiver holds rsp.ready low, the result holds and req is stalled.
//   reset: synchronous rst returns markers to 1, 2, 3, 4, clears the words,
//   counters and ready flag, and starts hunting for the first start marker.
module marker_framed_sample_deframer (
  input  logic                               clk,
  input  logic                               rst,
  mfsd_in_if.sink                            req,
  mfsd_out_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [mfsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mfsd_pkg::MARKER_BITS-1:0]    cfg_data
);

  localparam logic [2:0] PH_HUNT_A  = 3'd0;
  localparam logic [2:0] PH_START_B = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_END_A   = 3'd3;
  localparam logic [2:0] PH_END_B   = 3'd4;

  localparam logic [mfsd_pkg::CFG_INDEX_BITS-1:0] REG_START_A = 2'd0;
  localparam logic [mfsd_pkg::CFG_INDEX_BITS-1:0] REG_START_B = 2'd1;
  localparam logic [mfsd_pkg::CFG_INDEX_BITS-1:0] REG_END_A   = 2'd2;
  localparam logic [mfsd_pkg::CFG_INDEX_BITS-1:0] REG_END_B   = 2'd3;

  localparam logic [mfsd_pkg::WORD_IDX_BITS-1:0] LAST_WORD =
    mfsd_pkg::WORD_IDX_BITS'(mfsd_pkg::NUM_WORDS - 1);

  logic [mfsd_pkg::MARKER_BITS-1:0] start_marker_a;
  logic [mfsd_pkg::MARKER_BITS-1:0] start_marker_b;
  logic [mfsd_pkg::MARKER_BITS-1:0] end_marker_a;
  logic [mfsd_pkg::MARKER_BITS-1:0] end_marker_b;

  logic [2:0]                              phase, phase_next;
  logic [1:0]                              byte_in_word, byte_in_word_next;
  logic [mfsd_pkg::WORD_IDX_BITS-1:0]      word_index, word_index_next;
  logic [mfsd_pkg::WORD_IDX_BITS-1:0]      widx;
  logic [mfsd_pkg::WORD_BITS-1:0]          assembly [mfsd_pkg::NUM_WORDS];
  logic [mfsd_pkg::WORD_BITS-1:0]          assembly_next [mfsd_pkg::NUM_WORDS];
  logic [mfsd_pkg::WORD_BITS-1:0]          latched [mfsd_pkg::NUM_WORDS];
  logic [mfsd_pkg::WORD_BITS-1:0]          latched_next [mfsd_pkg::NUM_WORDS];
  logic                                    ready_flag, ready_flag_next;
  logic                                    taken, taken_next;
  logic [mfsd_pkg::COUNT_BITS-1:0]         frame_counter, frame_counter_next;
  logic [mfsd_pkg::COUNT_BITS-1:0]         sync_counter, sync_counter_next;
  logic [mfsd_pkg::COUNT_BITS-1:0]         overrun_counter, overrun_counter_next;
  logic                                    rsp_valid;
  logic                                    accept;
  logic [mfsd_pkg::MARKER_BITS-1:0]        b;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign b         = req.data.data_byte;
  assign widx      = (word_index > LAST_WORD) ? '0 : word_index;

  always_comb begin
    phase_next           = phase;
    byte_in_word_next    = byte_in_word;
    word_index_next      = word_index;
    assembly_next        = assembly;
    latched_next         = latched;
    ready_flag_next      = ready_flag;
    taken_next           = 1'b0;
    frame_counter_next   = frame_counter;
    sync_counter_next    = sync_counter;
    overrun_counter_next = overrun_counter;
    if (req.data.cmd == mfsd_pkg::CMD_READ) begin
      if (ready_flag) begin
        taken_next      = 1'b1;
        ready_flag_next = 1'b0;
      end
    end else begin
      case (phase)
        PH_START_B: begin
          if (b != start_marker_b) begin
            sync_counter_next = sync_counter + mfsd_pkg::COUNT_BITS'(1);
            phase_next        = PH_HUNT_A;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          assembly_next[widx][{byte_in_word, 3'b000} +: 8] = b;
          byte_in_word_next = byte_in_word + 2'd1;
          word_index_next   = widx;
          if (byte_in_word == 2'd3) begin
            if (widx == LAST_WORD) begin
              word_index_next = '0;
              phase_next      = PH_END_A;
            end else begin
              word_index_next = widx + mfsd_pkg::WORD_IDX_BITS'(1);
            end
          end
        end
        PH_END_A: begin
          if (b != end_marker_a) begin
            sync_counter_next = sync_counter + mfsd_pkg::COUNT_BITS'(1);
            phase_next        = PH_HUNT_A;
          end else begin
            phase_next = PH_END_B;
          end
        end
        PH_END_B: begin
          phase_next = PH_HUNT_A;
          if (b != end_marker_b) begin
            sync_counter_next = sync_counter + mfsd_pkg::COUNT_BITS'(1);
          end else begin
            if (ready_flag) begin
              overrun_counter_next = overrun_counter + mfsd_pkg::COUNT_BITS'(1);
            end
            frame_counter_next = frame_counter + mfsd_pkg::COUNT_BITS'(1);
            ready_flag_next    = 1'b1;
            latched_next       = assembly;
          end
        end
        default: begin
          if (b != start_marker_a) begin
            sync_counter_next = sync_counter + mfsd_pkg::COUNT_BITS'(1);
            phase_next        = PH_HUNT_A;
          end else begin
            phase_next        = PH_START_B;
            byte_in_word_next = '0;
            word_index_next   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker_a <= 8'd1;
      start_marker_b <= 8'd2;
      end_marker_a   <= 8'd3;
      end_marker_b   <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_A: start_marker_a <= cfg_data;
        REG_START_B: start_marker_b <= cfg_data;
        REG_END_A:   end_marker_a   <= cfg_data;
        REG_END_B:   end_marker_b   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT_A;
      byte_in_word    <= '0;
      word_index      <= '0;
      assembly        <= '{default: '0};
      latched         <= '{default: '0};
      ready_flag      <= 1'b0;
      taken           <= 1'b0;
      frame_counter   <= '0;
      sync_counter    <= '0;
      overrun_counter <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        byte_in_word    <= byte_in_word_next;
        word_index      <= word_index_next;
        assembly        <= assembly_next;
        latched         <= latched_next;
        ready_flag      <= ready_flag_next;
        taken           <= taken_next;
        frame_counter   <= frame_counter_next;
        sync_counter    <= sync_counter_next;
        overrun_counter <= overrun_counter_next;
        rsp_valid       <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result fields follow the state, which only moves when a request is accepted
  assign rsp.valid                 = rsp_valid;
  assign rsp.data.frame_ready      = ready_flag;
  assign rsp.data.frame_taken      = taken;
  assign rsp.data.time_word        = latched[0];
  assign rsp.data.eye_x_word       = latched[1];
  assign rsp.data.eye_y_word       = latched[2];
  assign rsp.data.frames_total     = frame_counter;
  assign rsp.data.sync_error_total = sync_counter;
  assign rsp.data.overrun_total    = overrun_counter;

`ifndef NO_ASSERTIONS
  a_taken_clears_ready: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && taken |-> !ready_flag)
    else $error("frame taken while ready flag still set");

  a_overrun_with_frame: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (overrun_counter != $past(overrun_counter))
      |-> (frame_counter != $past(frame_counter)))
    else $error("overrun counted without a completed frame");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(accept)
      |-> $stable(frame_counter) && $stable(sync_counter) && $stable(ready_flag))
    else $error("frame state moved without an accepted transaction");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |=> rsp_valid && $stable(rsp.data))
    else $error("pending result dropped or changed");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for marker_framed_sample_deframer, predicting every status
// result and comparing it field by field; depends on mfsd_pkg, mfsd_in_if, mfsd_out_if
module tb;

  typedef enum logic [2:0] {
    HUNT_SOM_A, HUNT_SOM_B, IN_PAYLOAD, WAIT_EOM_A, WAIT_EOM_B
  } sync_state_t;

  typedef enum logic [mfsd_pkg::CFG_INDEX_BITS-1:0] {
    REG_SOM_A, REG_SOM_B, REG_EOM_A, REG_EOM_B
  } marker_reg_t;

  typedef struct {
    logic                             cmd;
    logic [mfsd_pkg::MARKER_BITS-1:0] data;
    bit                               lit;
    mfsd_pkg::out_item_t              want;
  } probe_row_t;

  localparam int PROBE_ROWS     = 25;
  localparam int PHASE_ITEMS    = 105;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [mfsd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [mfsd_pkg::MARKER_BITS-1:0]    cfg_data;

  mfsd_in_if  req_ch ();
  mfsd_out_if rsp_ch ();

  marker_framed_sample_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // deframer model state
  logic [mfsd_pkg::MARKER_BITS-1:0] mk_som_a = 8'd1;
  logic [mfsd_pkg::MARKER_BITS-1:0] mk_som_b = 8'd2;
  logic [mfsd_pkg::MARKER_BITS-1:0] mk_eom_a = 8'd3;
  logic [mfsd_pkg::MARKER_BITS-1:0] mk_eom_b = 8'd4;
  sync_state_t                      frame_state = HUNT_SOM_A;
  logic [1:0]                       byte_slot = 2'd0;
  int unsigned                      word_slot = 0;
  logic [mfsd_pkg::WORD_BITS-1:0]   asm_words [mfsd_pkg::NUM_WORDS];
  logic [mfsd_pkg::WORD_BITS-1:0]   held_words [mfsd_pkg::NUM_WORDS];
  logic                             held_ready = 1'b0;
  logic [mfsd_pkg::COUNT_BITS-1:0]  frame_count = '0;
  logic [mfsd_pkg::COUNT_BITS-1:0]  sync_count = '0;
  logic [mfsd_pkg::COUNT_BITS-1:0]  overrun_count = '0;

  mfsd_pkg::out_item_t expected_status [$];
  probe_row_t          probe_rows [PROBE_ROWS];
  int                  items_sent = 0;
  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  bit                  send_calm = 1'b0;
  bit                  sink_calm = 1'b0;

  function automatic void lose_sync();
    sync_count++;
    frame_state = HUNT_SOM_A;
  endfunction

  function automatic mfsd_pkg::out_item_t step_deframer(mfsd_pkg::in_item_t it);
    mfsd_pkg::out_item_t r;
    logic                taken;
    taken = 1'b0;
    if (it.cmd == mfsd_pkg::CMD_READ) begin
      if (held_ready) begin
        taken = 1'b1;
        held_ready = 1'b0;
      end
    end else begin
      case (frame_state)
        HUNT_SOM_B: begin
          if (it.data_byte != mk_som_b) lose_sync();
          else frame_state = IN_PAYLOAD;
        end
        IN_PAYLOAD: begin
          asm_words[word_slot][{byte_slot, 3'b000} +: 8] = it.data_byte;
          byte_slot++;
          if (byte_slot == 2'd0) begin
            word_slot++;
            if (word_slot == mfsd_pkg::NUM_WORDS) begin
              word_slot = 0;
              frame_state = WAIT_EOM_A;
            end
          end
        end
        WAIT_EOM_A: begin
          if (it.data_byte != mk_eom_a) lose_sync();
          else frame_state = WAIT_EOM_B;
        end
        WAIT_EOM_B: begin
          if (it.data_byte != mk_eom_b) lose_sync();
          else begin
            frame_state = HUNT_SOM_A;
            if (held_ready) overrun_count++;
            frame_count++;
            held_ready = 1'b1;
            foreach (held_words[i]) held_words[i] = asm_words[i];
          end
        end
        default: begin
          if (it.data_byte != mk_som_a) lose_sync();
          else begin
            frame_state = HUNT_SOM_B;
            byte_slot = 2'd0;
            word_slot = 0;
          end
        end
      endcase
    end
    r.frame_ready      = held_ready;
    r.frame_taken      = taken;
    r.time_word        = held_words[0];
    r.eye_x_word       = held_words[1];
    r.eye_y_word       = held_words[2];
    r.frames_total     = frame_count;
    r.sync_error_total = sync_count;
    r.overrun_total    = overrun_count;
    return r;
  endfunction

  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // drive one transaction and return at the edge that accepts it
  task automatic put_item(input mfsd_pkg::in_item_t it, input bit lit = 1'b0,
                          input mfsd_pkg::out_item_t want = '0);
    int                  gap;
    mfsd_pkg::out_item_t pred;
    gap = idle_len(send_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pred = step_deframer(it);
    expected_status.push_back(lit ? want : pred);
    items_sent++;
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input marker_reg_t idx,
                           input logic [mfsd_pkg::MARKER_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SOM_A: mk_som_a = val;
      REG_SOM_B: mk_som_b = val;
      REG_EOM_A: mk_eom_a = val;
      REG_EOM_B: mk_eom_b = val;
      default: ;
    endcase
  endtask

  task automatic write_markers(input logic [7:0] sa, input logic [7:0] sb,
                               input logic [7:0] ea, input logic [7:0] eb);
    write_reg(REG_SOM_A, sa);
    write_reg(REG_SOM_B, sb);
    write_reg(REG_EOM_A, ea);
    write_reg(REG_EOM_B, eb);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input bit broken);
    logic [7:0] seq [$];
    int         pos;
    seq.push_back(mk_som_a);
    seq.push_back(mk_som_b);
    repeat (12) seq.push_back(8'($urandom));
    seq.push_back(mk_eom_a);
    seq.push_back(mk_eom_b);
    if (broken) begin
      pos = $urandom_range(0, 4);
      if (pos == 4) begin
        pos = $urandom_range(2, 14);
        while (seq.size() > pos) void'(seq.pop_back());
      end else begin
        pos = (pos < 2) ? pos : pos + 12;
        seq[pos] = seq[pos] ^ 8'($urandom_range(1, 255));
      end
    end
    foreach (seq[i]) begin
      if ($urandom_range(0, 11) == 0)
        put_item(mfsd_pkg::in_item_t'{mfsd_pkg::CMD_READ, 8'($urandom)});
      put_item(mfsd_pkg::in_item_t'{mfsd_pkg::CMD_BYTE, seq[i]});
    end
    if ($urandom_range(0, 9) < 6)
      put_item(mfsd_pkg::in_item_t'{mfsd_pkg::CMD_READ, 8'($urandom)});
  endtask

  task automatic run_traffic(input int count);
    int first;
    int r;
    first = items_sent;
    while (items_sent - first < count) begin
      send_calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 65) send_frame(1'b0);
      else if (r < 80) send_frame(1'b1);
      else if (r < 90)
        repeat ($urandom_range(1, 4))
          put_item(mfsd_pkg::in_item_t'{mfsd_pkg::CMD_BYTE, 8'($urandom)});
      else put_item(mfsd_pkg::in_item_t'{mfsd_pkg::CMD_READ, 8'($urandom)});
    end
  endtask

  // result sink with random back-pressure
  initial begin : sink
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      gap = idle_len(sink_calm);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    mfsd_pkg::out_item_t got;
    mfsd_pkg::out_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (expected_status.size() == 0) begin
        report_mismatch("result with no transaction pending", '0, '0);
      end else begin
        want = expected_status.pop_front();
        if (got.frame_ready !== want.frame_ready)
          report_mismatch("frame_ready", 32'(got.frame_ready), 32'(want.frame_ready));
        if (got.frame_taken !== want.frame_taken)
          report_mismatch("frame_taken", 32'(got.frame_taken), 32'(want.frame_taken));
        if (got.time_word !== want.time_word)
          report_mismatch("time_word", got.time_word, want.time_word);
        if (got.eye_x_word !== want.eye_x_word)
          report_mismatch("eye_x_word", got.eye_x_word, want.eye_x_word);
        if (got.eye_y_word !== want.eye_y_word)
          report_mismatch("eye_y_word", got.eye_y_word, want.eye_y_word);
        if (got.frames_total !== want.frames_total)
          report_mismatch("frames_total", got.frames_total, want.frames_total);
        if (got.sync_error_total !== want.sync_error_total)
          report_mismatch("sync_error_total", got.sync_error_total, want.sync_error_total);
        if (got.overrun_total !== want.overrun_total)
          report_mismatch("overrun_total", got.overrun_total, want.overrun_total);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : main
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_SOM_A;
    cfg_data     <= '0;
    foreach (asm_words[i]) begin
      asm_words[i]  = '0;
      held_words[i] = '0;
    end
    // default markers 01 02 03 04 after reset
    probe_rows = '{
      '{mfsd_pkg::CMD_READ, 8'h55, 1'b1, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h00, 1'b1,
        mfsd_pkg::out_item_t'{sync_error_total: 32'd1, default: '0}},
      '{mfsd_pkg::CMD_BYTE, 8'hFF, 1'b1,
        mfsd_pkg::out_item_t'{sync_error_total: 32'd2, default: '0}},
      '{mfsd_pkg::CMD_BYTE, 8'h01, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h02, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h00, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'hFF, 1'b0, '0},
      '{mfsd_pkg::CMD_READ, 8'hAA, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h80, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h7F, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h01, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h02, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h03, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h04, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h55, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'hAA, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'hFE, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h01, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h03, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h04, 1'b0, '0},
      '{mfsd_pkg::CMD_READ, 8'hFF, 1'b0, '0},
      '{mfsd_pkg::CMD_READ, 8'h00, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h01, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h09, 1'b0, '0},
      '{mfsd_pkg::CMD_BYTE, 8'h04, 1'b0, '0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i])
      put_item(mfsd_pkg::in_item_t'{probe_rows[i].cmd, probe_rows[i].data},
               probe_rows[i].lit, probe_rows[i].want);
    run_traffic(PHASE_ITEMS);
    wait_idle();

    write_markers(8'hFF, 8'h00, 8'hFF, 8'h00);
    run_traffic(PHASE_ITEMS);
    wait_idle();

    write_markers(8'h00, 8'hFF, 8'h00, 8'hFF);
    run_traffic(PHASE_ITEMS);
    wait_idle();

    write_markers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_traffic(PHASE_ITEMS);
    wait_idle();

    // every marker the same byte
    write_markers(8'h7E, 8'h7E, 8'h7E, 8'h7E);
    run_traffic(PHASE_ITEMS);
    wait_idle();

    write_markers(8'h01, 8'h02, 8'h03, 8'h04);
    run_traffic(PHASE_ITEMS);
    wait_idle();

    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
